// ----- hdl/clifford_tableau_gate_update_top_defines.svh -----
// ----------------------------------------------------------------------------
// clifford_tableau_gate_update_top_defines
// assertion macros for the tableau gate unit
// ----------------------------------------------------------------------------
`ifndef CLIFFORD_TABLEAU_GATE_UPDATE_TOP_DEFINES_SVH
`define CLIFFORD_TABLEAU_GATE_UPDATE_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define CTG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/ctg_pkg.sv -----
// ----------------------------------------------------------------------------
// ctg_pkg
// types, opcodes and gate functions for the stabilizer tableau gate unit
// ----------------------------------------------------------------------------
package ctg_pkg;

    localparam int MaxQubits = 32;
    localparam int QW        = 5;
    localparam int RowW      = 64;

    typedef logic [RowW-1:0] col_t;

    typedef enum logic [4:0] {
        FN_INIT  = 5'd0,  FN_H    = 5'd1,  FN_S    = 5'd2,  FN_SDG  = 5'd3,
        FN_SX    = 5'd4,  FN_SXDG = 5'd5,  FN_X    = 5'd6,  FN_Y    = 5'd7,
        FN_Z     = 5'd8,  FN_CX   = 5'd9,  FN_CY   = 5'd10, FN_CZ   = 5'd11,
        FN_SWAP  = 5'd12, FN_ISWAP = 5'd13, FN_DCX = 5'd14, FN_ECR  = 5'd15,
        FN_READ  = 5'd16
    } func_t;

    localparam logic CFG_NUM_QUBITS = 1'b0;
    localparam logic CFG_WITH_DESTAB = 1'b1;

    typedef struct packed {
        col_t x;
        col_t z;
    } qcol_t;

    // decoded request handed from the decoder to the tableau datapath
    typedef struct packed {
        logic        valid;
        logic        err;
        logic        init;
        logic        read;
        logic [4:0]  func;
        logic [QW-1:0] qa;
        logic [QW-1:0] qb;
    } req_t;

    typedef struct packed {
        qcol_t a;
        qcol_t b;
        col_t  ph;
    } gstate_t;

    function automatic gstate_t g_h(input gstate_t s, input logic on_b);
        gstate_t r;
        qcol_t   c;
        r = s;
        c = on_b ? s.b : s.a;
        r.ph = s.ph ^ (c.x & c.z);
        if (on_b) begin
            r.b.x = c.z;
            r.b.z = c.x;
        end else begin
            r.a.x = c.z;
            r.a.z = c.x;
        end
        return r;
    endfunction

    function automatic gstate_t g_s(input gstate_t s, input logic on_b);
        gstate_t r;
        qcol_t   c;
        r = s;
        c = on_b ? s.b : s.a;
        r.ph = s.ph ^ (c.x & c.z);
        if (on_b) r.b.z = c.z ^ c.x;
        else r.a.z = c.z ^ c.x;
        return r;
    endfunction

    // controlled-x, control b when rev is set
    function automatic gstate_t g_cx(input gstate_t s, input logic rev);
        gstate_t r;
        qcol_t   c;
        qcol_t   t;
        r = s;
        c = rev ? s.b : s.a;
        t = rev ? s.a : s.b;
        r.ph = s.ph ^ (c.x & t.z & ~(t.x ^ c.z));
        c.z = c.z ^ t.z;
        t.x = t.x ^ c.x;
        if (rev) begin
            r.b = c;
            r.a = t;
        end else begin
            r.a = c;
            r.b = t;
        end
        return r;
    endfunction

    function automatic gstate_t g_sdg(input gstate_t s, input logic on_b);
        return g_s(g_s(g_s(s, on_b), on_b), on_b);
    endfunction

    function automatic gstate_t g_z(input gstate_t s, input logic on_b);
        return g_s(g_s(s, on_b), on_b);
    endfunction

    function automatic gstate_t g_x(input gstate_t s, input logic on_b);
        return g_h(g_z(g_h(s, on_b), on_b), on_b);
    endfunction

    function automatic gstate_t g_sx(input gstate_t s, input logic on_b);
        return g_sdg(g_h(g_sdg(s, on_b), on_b), on_b);
    endfunction

    function automatic gstate_t apply_gate(input gstate_t s, input logic [4:0] f);
        gstate_t r;
        r = s;
        case (f)
            FN_H:     r = g_h(s, 1'b0);
            FN_S:     r = g_s(s, 1'b0);
            FN_SDG:   r = g_sdg(s, 1'b0);
            FN_SX:    r = g_sx(s, 1'b0);
            FN_SXDG:  r = g_s(g_h(g_s(s, 1'b0), 1'b0), 1'b0);
            FN_X:     r = g_x(s, 1'b0);
            FN_Y:     r = g_z(g_x(s, 1'b0), 1'b0);
            FN_Z:     r = g_z(s, 1'b0);
            FN_CX:    r = g_cx(s, 1'b0);
            FN_CY:    r = g_s(g_cx(g_sdg(s, 1'b1), 1'b0), 1'b1);
            FN_CZ:    r = g_h(g_cx(g_h(s, 1'b1), 1'b0), 1'b1);
            FN_SWAP:  r = g_cx(g_cx(g_cx(s, 1'b0), 1'b1), 1'b0);
            FN_ISWAP: r = g_h(g_cx(g_cx(g_h(g_s(g_s(s, 1'b1), 1'b0), 1'b0), 1'b0),
                              1'b1), 1'b1);
            FN_DCX:   r = g_cx(g_cx(s, 1'b0), 1'b1);
            FN_ECR:   r = g_x(g_cx(g_sx(g_s(s, 1'b0), 1'b1), 1'b0), 1'b0);
            default:  r = s;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/clifford_tableau_gate_update_top.sv -----
// result: registered, shown on the master side in the cycle after an item is accepted
// throughput: one item per cycle while the master side is not stalled, each gate is one pass of column logic
// reset: tableau returns to the 32-qubit diagonal with destabilizers,
//        num_qubits = 32, with_destabilizers = 1, no result pending
// ----------------------------------------------------------------------------
// clifford_tableau_gate_update_top
// stabilizer tableau unit applying one clifford gate per item
// ----------------------------------------------------------------------------
`include "clifford_tableau_gate_update_top_defines.svh"
module clifford_tableau_gate_update_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // func[4:0], qubit_a[9:5], qubit_b[14:10]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,   // error, is_identity, x_column, z_column, phase_bits
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [5:0]   cfg_data
);
    import ctg_pkg::*;

    logic [5:0]  nq_reg;
    logic        destab_reg;
    logic [6:0]  n_eff;
    logic        accept;
    logic        ovalid_reg;
    logic        err_reg;
    req_t        req;
    logic        is_identity;
    col_t        x_column;
    col_t        z_column;
    col_t        phase_bits;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign n_eff = (nq_reg == 6'd0) ? 7'd1 : ((nq_reg > 6'd32) ? 7'd32 : {1'b0, nq_reg});

    ctg_decode u_dec (
        .func    (s_axis_tdata[4:0]),
        .qubit_a (s_axis_tdata[9:5]),
        .qubit_b (s_axis_tdata[14:10]),
        .valid   (accept),
        .n_eff   (n_eff),
        .req     (req)
    );

    ctg_tableau u_tab (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .n_eff       (n_eff),
        .destab      (destab_reg),
        .is_identity (is_identity),
        .x_column    (x_column),
        .z_column    (z_column),
        .phase_bits  (phase_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            nq_reg     <= 6'd32;
            destab_reg <= 1'b1;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_NUM_QUBITS) nq_reg <= cfg_data;
                else destab_reg <= cfg_data[0];
            end
            if (accept) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) err_reg <= req.err;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'b0, phase_bits, z_column, x_column, is_identity, err_reg};

    `CTG_ASSERT_NEXT(a_out_after_accept, accept, m_axis_tvalid, "no result after item")
    `CTG_ASSERT_IMP(a_no_drop, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "item taken while result stalled")
    `CTG_ASSERT_NEXT(a_err_no_cols, accept && req.err,
        m_axis_tdata[129:2] == '0, "columns shown on error")

endmodule

// ----- hdl/ctg_decode.sv -----
// ----------------------------------------------------------------------------
// ctg_decode
// checks qubit indices against the configured count and each other, and classifies the item
// ----------------------------------------------------------------------------
module ctg_decode (
    input  logic [4:0]           func,
    input  logic [ctg_pkg::QW-1:0] qubit_a,
    input  logic [ctg_pkg::QW-1:0] qubit_b,
    input  logic                 valid,
    input  logic [6:0]           n_eff,
    output ctg_pkg::req_t        req
);
    import ctg_pkg::*;

    logic a_bad;
    logic b_bad;
    logic two_q;

    always_comb
    begin
        a_bad = {2'b00, qubit_a} >= n_eff;
        b_bad = ({2'b00, qubit_b} >= n_eff) || (qubit_a == qubit_b);
        two_q = (func >= FN_CX) && (func <= FN_ECR);
        req.valid = valid;
        req.init  = (func == FN_INIT);
        req.read  = (func == FN_READ) && !a_bad;
        req.err   = !req.init && ((func > FN_READ) || a_bad || (two_q && b_bad));
        req.func  = func;
        req.qa    = qubit_a;
        req.qb    = qubit_b;
    end

endmodule

// ----- hdl/ctg_tableau.sv -----
// ----------------------------------------------------------------------------
// ctg_tableau
// column store, gate datapath and identity check
// ----------------------------------------------------------------------------
module ctg_tableau (
    input  logic            clk,
    input  logic            rst_n,
    input  ctg_pkg::req_t   req,
    input  logic [6:0]      n_eff,
    input  logic            destab,
    output logic            is_identity,
    output ctg_pkg::col_t   x_column,
    output ctg_pkg::col_t   z_column,
    output ctg_pkg::col_t   phase_bits
);
    import ctg_pkg::*;

    col_t    x_reg [MaxQubits];
    col_t    z_reg [MaxQubits];
    col_t    ph_reg;
    col_t    x_next [MaxQubits];
    col_t    z_next [MaxQubits];
    col_t    ph_next;
    col_t    mask;
    gstate_t gin;
    gstate_t gout;
    logic    gate_en;
    logic    ident;
    logic    ident_reg;
    col_t    xcol_reg;
    col_t    zcol_reg;
    col_t    phcol_reg;

    always_comb
    begin
        mask = destab ? ((n_eff == 7'd32) ? '1 : ((col_t'(1) << {n_eff, 1'b0}) - 1'b1))
                      : ((col_t'(1) << n_eff) - 1'b1);
        gin.a.x = x_reg[req.qa];
        gin.a.z = z_reg[req.qa];
        gin.b.x = x_reg[req.qb];
        gin.b.z = z_reg[req.qb];
        gin.ph  = ph_reg;
        gout    = apply_gate(gin, req.func);
        gate_en = req.valid && !req.err && !req.init && !req.read;
        x_next  = x_reg;
        z_next  = z_reg;
        ph_next = ph_reg;
        if (req.valid && req.init) begin
            ph_next = '0;
            for (int q = 0; q < MaxQubits; q++) begin
                x_next[q] = '0;
                z_next[q] = '0;
                if (q < n_eff) begin
                    if (destab) begin
                        x_next[q] = col_t'(1) << q;
                        z_next[q] = col_t'(1) << (n_eff + 7'(q));
                    end else begin
                        z_next[q] = col_t'(1) << q;
                    end
                end
            end
        end else if (gate_en) begin
            // a written after b; b equals a only for one-qubit gates where b is untouched
            x_next[req.qb] = gout.b.x;
            z_next[req.qb] = gout.b.z;
            x_next[req.qa] = gout.a.x;
            z_next[req.qa] = gout.a.z;
            ph_next = gout.ph;
        end
    end

    always_comb
    begin
        ident = ((ph_next & mask) == '0);
        for (int q = 0; q < MaxQubits; q++) begin
            if (q < n_eff) begin
                if ((x_next[q] & mask) != (col_t'(1) << q)) ident = 1'b0;
                if ((z_next[q] & mask) !=
                    (destab ? (col_t'(1) << (n_eff + 7'(q))) : '0)) ident = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int q = 0; q < MaxQubits; q++) begin
                x_reg[q] <= col_t'(1) << q;
                z_reg[q] <= col_t'(1) << (32 + q);
            end
            ph_reg <= '0;
        end else begin
            x_reg  <= x_next;
            z_reg  <= z_next;
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid) begin
            ident_reg <= ident;
            xcol_reg  <= req.read ? (x_reg[req.qa] & mask) : '0;
            zcol_reg  <= req.read ? (z_reg[req.qa] & mask) : '0;
            phcol_reg <= ph_next & mask;
        end
    end

    assign is_identity = ident_reg;
    assign x_column    = xcol_reg;
    assign z_column    = zcol_reg;
    assign phase_bits  = phcol_reg;

endmodule
